FILE: hdl/vne_pkg.sv
package vne_pkg;

  // Grid limits
  localparam int unsigned GRID_SIZE_MAX = 1024;
  localparam int unsigned IDX_W         = $clog2(GRID_SIZE_MAX);
  localparam int unsigned SIZE_W        = IDX_W + 1;

  // Neighbour table geometry
  localparam int unsigned MAX_NB = 12;
  localparam int unsigned SEL_W  = $clog2(MAX_NB);

  // Front/back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register file
  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_FACE   = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_CORNER = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Per-axis step of an offset; also indexes the per-axis inside flags.
  typedef enum logic [1:0] {
    DIR_NEG  = 2'd0,
    DIR_ZERO = 2'd1,
    DIR_POS  = 2'd2,
    DIR_BAD  = 2'd3
  } dir_e;

  typedef struct packed {
    logic used;
    dir_e dx;
    dir_e dy;
    dir_e dz;
  } off_t;

  typedef struct packed {
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] z;
  } grid_size_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  cx;
    logic [IDX_W-1:0]  cy;
    logic [IDX_W-1:0]  cz;
    logic [MAX_NB-1:0] mask;
  } item_t;

  function automatic off_t mk_off(input dir_e dx, input dir_e dy, input dir_e dz);
    off_t o;
    o.used = 1'b1;
    o.dx   = dx;
    o.dy   = dy;
    o.dz   = dz;
    return o;
  endfunction

  // Offset table in emission order; entries past the class count are unused.
  function automatic off_t nb_offset(input cmd_e cmd, input logic [SEL_W-1:0] sel);
    off_t o;
    o = '{used: 1'b0, dx: DIR_ZERO, dy: DIR_ZERO, dz: DIR_ZERO};
    case (cmd)
      CMD_FACE: begin
        case (sel)
          4'd0:    o = mk_off(DIR_NEG,  DIR_ZERO, DIR_ZERO);
          4'd1:    o = mk_off(DIR_POS,  DIR_ZERO, DIR_ZERO);
          4'd2:    o = mk_off(DIR_ZERO, DIR_NEG,  DIR_ZERO);
          4'd3:    o = mk_off(DIR_ZERO, DIR_POS,  DIR_ZERO);
          4'd4:    o = mk_off(DIR_ZERO, DIR_ZERO, DIR_NEG);
          4'd5:    o = mk_off(DIR_ZERO, DIR_ZERO, DIR_POS);
          default: o.used = 1'b0;
        endcase
      end
      CMD_EDGE: begin
        case (sel)
          4'd0:    o = mk_off(DIR_NEG,  DIR_ZERO, DIR_NEG);
          4'd1:    o = mk_off(DIR_POS,  DIR_ZERO, DIR_NEG);
          4'd2:    o = mk_off(DIR_POS,  DIR_ZERO, DIR_POS);
          4'd3:    o = mk_off(DIR_NEG,  DIR_ZERO, DIR_POS);
          4'd4:    o = mk_off(DIR_NEG,  DIR_POS,  DIR_ZERO);
          4'd5:    o = mk_off(DIR_NEG,  DIR_NEG,  DIR_ZERO);
          4'd6:    o = mk_off(DIR_POS,  DIR_NEG,  DIR_ZERO);
          4'd7:    o = mk_off(DIR_POS,  DIR_POS,  DIR_ZERO);
          4'd8:    o = mk_off(DIR_ZERO, DIR_POS,  DIR_POS);
          4'd9:    o = mk_off(DIR_ZERO, DIR_POS,  DIR_NEG);
          4'd10:   o = mk_off(DIR_ZERO, DIR_NEG,  DIR_NEG);
          4'd11:   o = mk_off(DIR_ZERO, DIR_NEG,  DIR_POS);
          default: o.used = 1'b0;
        endcase
      end
      CMD_CORNER: begin
        case (sel)
          4'd0:    o = mk_off(DIR_POS, DIR_POS, DIR_POS);
          4'd1:    o = mk_off(DIR_POS, DIR_NEG, DIR_POS);
          4'd2:    o = mk_off(DIR_NEG, DIR_NEG, DIR_POS);
          4'd3:    o = mk_off(DIR_NEG, DIR_POS, DIR_POS);
          4'd4:    o = mk_off(DIR_POS, DIR_POS, DIR_NEG);
          4'd5:    o = mk_off(DIR_POS, DIR_NEG, DIR_NEG);
          4'd6:    o = mk_off(DIR_NEG, DIR_NEG, DIR_NEG);
          4'd7:    o = mk_off(DIR_NEG, DIR_POS, DIR_NEG);
          default: o.used = 1'b0;
        endcase
      end
      default: o.used = 1'b0;
    endcase
    return o;
  endfunction

  // Apply one axis step; only used on in-grid results, so wrap is harmless.
  function automatic logic [IDX_W-1:0] step_axis(input logic [IDX_W-1:0] c, input dir_e d);
    logic [IDX_W-1:0] r;
    case (d)
      DIR_NEG: r = c - IDX_W'(1);
      DIR_POS: r = c + IDX_W'(1);
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/voxel_neighbour_enumerator.sv
// Voxel neighbour enumerator.
// Input channel (in_valid_i / in_stall_o): one transfer carries a command
// (face, edge or corner) and the x/y/z index of a centre cell. Output
// channel (out_valid_o / out_stall_i): one transfer per in-grid neighbour,
// in the fixed table order of the class, with last_o on the final one. If
// no neighbour is inside the grid (or the command is unused) a single
// transfer with found_o=0, last_o=1 and zero coordinates is sent.
// Grid sizes live in three APB registers (size_x/y/z at 0x0/0x4/0x8, 11 bits,
// sizes above 1024 act as 1024). Write them only while the block is idle.
// An item passes the queue, the current-item register and then the output
// register. It yields max(1, N) results, N = in-grid neighbours (up to 12);
// the back-end emitter produces one result per cycle while the output is
// not stalled. The front classifies an item in its accept cycle into a
// two-entry queue, so input keeps flowing while the back end works or the
// receiver stalls. A stall on the output holds the result register; the
// queue fills and then in_stall_o rises. Reset empties the queue and output
// register and sets all three sizes to 1024.
module voxel_neighbour_enumerator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vne_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_x_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_y_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_z_i,
  // Output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [vne_pkg::IDX_W-1:0] nb_x_o,
  output logic [vne_pkg::IDX_W-1:0] nb_y_o,
  output logic [vne_pkg::IDX_W-1:0] nb_z_o,
  output logic                      found_o,
  output logic                      last_o
);
  import vne_pkg::*;

  grid_size_t size_q, size_d;
  reg_idx_e   reg_idx;
  logic       wr_en;

  logic       push, pop, q_full, q_valid;
  item_t      push_item, q_item;

  // Register file: register i sits at byte address 4*i
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    size_d = size_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SIZE_X: size_d.x = pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_d.y = pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_d.z = pwdata[SIZE_W-1:0];
        default:    size_d   = size_q;   // no register there
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_X: prdata = 32'(size_q.x);
      REG_SIZE_Y: prdata = 32'(size_q.y);
      REG_SIZE_Z: prdata = 32'(size_q.z);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q.x <= SIZE_W'(GRID_SIZE_MAX);
      size_q.y <= SIZE_W'(GRID_SIZE_MAX);
      size_q.z <= SIZE_W'(GRID_SIZE_MAX);
    end else begin
      size_q <= size_d;
    end
  end

  // Front: classify each centre cell into a mask of in-grid candidates
  vne_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .cell_x_i   (cell_x_i),
    .cell_y_i   (cell_y_i),
    .cell_z_i   (cell_z_i),
    .size_i     (size_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Decoupling queue between classification and emission
  vne_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Back: walk the mask, one neighbour per cycle unless the output stalls, into the output register
  vne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .nb_x_o      (nb_x_o),
    .nb_y_o      (nb_y_o),
    .nb_z_o      (nb_z_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  a_size_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && (reg_idx == REG_SIZE_X) |=> size_q.x == $past(pwdata[SIZE_W-1:0]))
    else $error("size_x write lost");
  a_size_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(size_q))
    else $error("sizes changed without a write");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled with room in queue");
`endif

endmodule

FILE: hdl/vne_front.sv
module vne_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_x_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_y_i,
  input  logic [vne_pkg::IDX_W-1:0] cell_z_i,
  input  vne_pkg::grid_size_t       size_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output vne_pkg::item_t            item_o
);
  import vne_pkg::*;

  logic [SIZE_W-1:0] lim_x, lim_y, lim_z;
  logic [2:0]        ok_x, ok_y, ok_z;
  cmd_e              cmd;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
    return (s > SIZE_W'(GRID_SIZE_MAX)) ? SIZE_W'(GRID_SIZE_MAX) : s;
  endfunction

  // Inside flags per step: c-1, c, c+1 against [0, lim)
  function automatic logic [2:0] axis_ok(input logic [IDX_W-1:0] c,
                                         input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] cw;
    logic [2:0]        ok;
    cw            = {1'b0, c};
    ok[DIR_NEG]   = (c != '0) && (cw <= lim);
    ok[DIR_ZERO]  = cw < lim;
    ok[DIR_POS]   = (cw + SIZE_W'(1)) < lim;
    return ok;
  endfunction

  assign lim_x = sat_size(size_i.x);
  assign lim_y = sat_size(size_i.y);
  assign lim_z = sat_size(size_i.z);
  assign ok_x  = axis_ok(cell_x_i, lim_x);
  assign ok_y  = axis_ok(cell_y_i, lim_y);
  assign ok_z  = axis_ok(cell_z_i, lim_z);
  assign cmd   = cmd_e'(command_i);

  always_comb begin
    off_t o;
    item_o.cmd = cmd;
    item_o.cx  = cell_x_i;
    item_o.cy  = cell_y_i;
    item_o.cz  = cell_z_i;
    for (int i = 0; i < MAX_NB; i++) begin
      o = nb_offset(cmd, SEL_W'(i));
      item_o.mask[i] = o.used && ok_x[o.dx[1:0]] && ok_y[o.dy[1:0]] && ok_z[o.dz[1:0]];
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

`ifndef SYNTHESIS
  // Unused command never yields a candidate
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (cmd == CMD_NONE) |-> item_o.mask == '0)
    else $error("unused command produced a candidate");
  // Face class has only six entries
  a_face_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (cmd == CMD_FACE) |-> item_o.mask[MAX_NB-1:6] == '0)
    else $error("face class marked entry past its table");
  // Corner class has only eight entries
  a_corner_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (cmd == CMD_CORNER) |-> item_o.mask[MAX_NB-1:8] == '0)
    else $error("corner class marked entry past its table");
`endif

endmodule

FILE: hdl/vne_queue.sv
module vne_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vne_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output vne_pkg::item_t item_o
);
  import vne_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] inc_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? inc_ptr(wr_q) : wr_q;
    rd_d  = pop_i  ? inc_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/vne_back.sv
module vne_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  vne_pkg::item_t            q_item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [vne_pkg::IDX_W-1:0] nb_x_o,
  output logic [vne_pkg::IDX_W-1:0] nb_y_o,
  output logic [vne_pkg::IDX_W-1:0] nb_z_o,
  output logic                      found_o,
  output logic                      last_o
);
  import vne_pkg::*;

  // Current item
  logic              active_q, active_d;
  item_t             cur_q, cur_d;
  // Output register
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  nb_x_q, nb_x_d, nb_y_q, nb_y_d, nb_z_q, nb_z_d;
  logic              found_q, found_d, last_q, last_d;

  logic [SEL_W-1:0]  sel;
  logic [MAX_NB-1:0] pick, rest;
  logic              adv, emit_last, load;
  off_t              off;

  // Lowest pending candidate
  assign pick = cur_q.mask & (~cur_q.mask + MAX_NB'(1));
  assign rest = cur_q.mask & ~pick;

  always_comb begin
    sel = '0;
    for (int i = MAX_NB - 1; i >= 0; i--) begin
      if (cur_q.mask[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign off       = nb_offset(cur_q.cmd, sel);
  assign adv       = active_q && (!out_valid_q || !out_stall_i);
  assign emit_last = rest == '0;
  assign load      = q_valid_i && (!active_q || (adv && emit_last));
  assign pop_o     = load;

  always_comb begin
    active_d    = active_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    nb_x_d      = nb_x_q;
    nb_y_d      = nb_y_q;
    nb_z_d      = nb_z_q;
    found_d     = found_q;
    last_d      = last_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      found_d     = cur_q.mask != '0;
      last_d      = emit_last;
      if (cur_q.mask != '0) begin
        nb_x_d = step_axis(cur_q.cx, off.dx);
        nb_y_d = step_axis(cur_q.cy, off.dy);
        nb_z_d = step_axis(cur_q.cz, off.dz);
      end else begin
        nb_x_d = '0;
        nb_y_d = '0;
        nb_z_d = '0;
      end
      cur_d.mask = rest;
      if (emit_last) begin
        active_d = 1'b0;
      end
    end

    if (load) begin
      active_d = 1'b1;
      cur_d    = q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    nb_x_q  <= nb_x_d;
    nb_y_q  <= nb_y_d;
    nb_z_q  <= nb_z_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign nb_x_o      = nb_x_q;
  assign nb_y_o      = nb_y_q;
  assign nb_z_o      = nb_z_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o)
    else $error("empty result not marked last");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (nb_x_o == '0) && (nb_y_o == '0) && (nb_z_o == '0))
    else $error("empty result carries coordinates");
  a_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit_last && !q_valid_i |=> !active_q)
    else $error("item still active after its last result");
  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && (cur_q.mask != '0) |-> $onehot(pick) && pick[sel])
    else $error("candidate select mismatch");
`endif

endmodule

FILE: bench/tb_voxel_neighbour_enumerator.sv
module tb_voxel_neighbour_enumerator;
  timeunit 1ns;
  timeprecision 1ps;

  import vne_pkg::*;

  // One output transfer as seen on the result channel.
  typedef struct packed {
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] z;
    logic             found;
    logic             last;
  } nb_result_t;

  // Directed probe: grid sizes to load, the centre cell, and optionally a
  // hand-written single result (otherwise the predictor decides).
  typedef struct {
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    cmd_e              cmd;
    logic [IDX_W-1:0]  x;
    logic [IDX_W-1:0]  y;
    logic [IDX_W-1:0]  z;
    bit                typed;
    nb_result_t        want;
  } probe_t;

  // The lone "nothing inside" transfer.
  localparam nb_result_t NO_NB = '{x: '0, y: '0, z: '0, found: 1'b0, last: 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        command_i;
  logic [IDX_W-1:0]  cell_x_i;
  logic [IDX_W-1:0]  cell_y_i;
  logic [IDX_W-1:0]  cell_z_i;

  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  nb_x_o;
  logic [IDX_W-1:0]  nb_y_o;
  logic [IDX_W-1:0]  nb_z_o;
  logic              found_o;
  logic              last_o;

  // Local copy of the size registers, as last written.
  logic [SIZE_W-1:0] grid_x;
  logic [SIZE_W-1:0] grid_y;
  logic [SIZE_W-1:0] grid_z;

  nb_result_t pending_nb_q[$];   // neighbor transfers still owed by the block
  probe_t     probe_list[$];

  int  mismatch_cnt = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  grid_loads   = 0;
  bit  tx_calm      = 1'b0;      // sender adds no random gaps while set
  bit  rx_calm      = 1'b0;      // receiver starts no new stall while set

  always #5 clk_i = ~clk_i;

  voxel_neighbour_enumerator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .nb_x_o      (nb_x_o),
    .nb_y_o      (nb_y_o),
    .nb_z_o      (nb_z_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("ERROR @%0t result %0d: %s", $realtime, results_seen, msg);
  endtask

  // Offsets per class, in emission order, as dx dy dz sign triples.
  function automatic string offset_list(input cmd_e cmd);
    case (cmd)
      CMD_FACE:   return "-00 +00 0-0 0+0 00- 00+";
      CMD_EDGE:   return "-0- +0- +0+ -0+ -+0 --0 +-0 ++0 0++ 0+- 0-- 0-+";
      CMD_CORNER: return "+++ +-+ --+ -++ ++- +-- --- -+-";
      default:    return "";
    endcase
  endfunction

  // Works out the neighbor transfers for one centre cell and queues them.
  function automatic void predict_neighbours(input cmd_e cmd, input logic [IDX_W-1:0] cx,
                                             input logic [IDX_W-1:0] cy,
                                             input logic [IDX_W-1:0] cz);
    string      offs;
    int         ctr[3];
    int         lim[3];
    int         pos[3];
    int         step;
    int         n;
    bit         in_grid;
    nb_result_t hits[MAX_NB];
    offs   = offset_list(cmd);
    ctr[0] = cx;
    ctr[1] = cy;
    ctr[2] = cz;
    // sizes above the maximum act as the maximum
    lim[0] = (grid_x > GRID_SIZE_MAX) ? GRID_SIZE_MAX : grid_x;
    lim[1] = (grid_y > GRID_SIZE_MAX) ? GRID_SIZE_MAX : grid_y;
    lim[2] = (grid_z > GRID_SIZE_MAX) ? GRID_SIZE_MAX : grid_z;
    n = 0;
    for (int k = 0; 4 * k < offs.len(); k++) begin
      in_grid = 1'b1;
      for (int a = 0; a < 3; a++) begin
        step   = (offs[4*k+a] == "-") ? -1 : (offs[4*k+a] == "+") ? 1 : 0;
        pos[a] = ctr[a] + step;
        if (pos[a] < 0 || pos[a] >= lim[a]) in_grid = 1'b0;
      end
      if (in_grid) begin
        hits[n] = '{x: IDX_W'(pos[0]), y: IDX_W'(pos[1]), z: IDX_W'(pos[2]),
                    found: 1'b1, last: 1'b0};
        n++;
      end
    end
    if (n == 0) begin
      pending_nb_q.push_back(NO_NB);
    end else begin
      hits[n-1].last = 1'b1;
      for (int j = 0; j < n; j++) pending_nb_q.push_back(hits[j]);
    end
  endfunction

  // APB write: setup, then access until pready, then back to idle.
  task automatic write_reg(input reg_idx_e idx, input logic [SIZE_W-1:0] val);
    logic [31:0] word;
    word         = $urandom;
    word[SIZE_W-1:0] = val;   // upper bits are random, only the low ones count
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SIZE_X: grid_x = val;
      REG_SIZE_Y: grid_y = val;
      REG_SIZE_Z: grid_z = val;
      default: ;   // unmapped address, ignored
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold input off until every owed transfer is back, plus the pipe depth.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_nb_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_grid(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                            input logic [SIZE_W-1:0] sz);
    settle_block();
    write_reg(REG_NONE, SIZE_W'($urandom));
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    grid_loads++;
  endtask

  // One input transfer. Valid stays high after acceptance so back-to-back
  // items need no second assignment in the same step.
  task automatic send_item(input cmd_e cmd, input logic [IDX_W-1:0] cx,
                           input logic [IDX_W-1:0] cy, input logic [IDX_W-1:0] cz,
                           input bit typed, input nb_result_t want);
    int r;
    int gap;
    r   = $urandom_range(0, 9);
    gap = tx_calm ? 0 : (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    cell_x_i   <= cx;
    cell_y_i   <= cy;
    cell_z_i   <= cz;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) pending_nb_q.push_back(want);
    else predict_neighbours(cmd, cx, cy, cz);
    items_sent++;
  endtask

  task automatic add_probe(input int sx, input int sy, input int sz, input cmd_e cmd,
                           input int x, input int y, input int z,
                           input bit typed, input nb_result_t want);
    probe_t p;
    p.sx    = SIZE_W'(sx);
    p.sy    = SIZE_W'(sy);
    p.sz    = SIZE_W'(sz);
    p.cmd   = cmd;
    p.x     = IDX_W'(x);
    p.y     = IDX_W'(y);
    p.z     = IDX_W'(z);
    p.typed = typed;
    p.want  = want;
    probe_list.push_back(p);
  endtask

  // Random sizes lean to small grids so the edges get hit often.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(2);
      3, 4, 5: return SIZE_W'($urandom_range(3, 12));
      6:       return SIZE_W'($urandom_range(13, 1023));
      7:       return SIZE_W'(GRID_SIZE_MAX);
      8:       return SIZE_W'($urandom_range(GRID_SIZE_MAX + 1, 2047));
      default: return '1;
    endcase
  endfunction

  // Centre cell near the faces of the grid, just outside it, or anywhere.
  function automatic logic [IDX_W-1:0] pick_cell(input int size);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1;
      2:       v = size - 1;
      3:       v = size - 2;
      4:       v = size;
      5:       v = (size > 1) ? $urandom_range(0, size - 1) : 0;
      6:       v = $urandom_range(0, 1023);
      default: v = 1023;
    endcase
    return IDX_W'(v);
  endfunction

  // Receiver: random stall pattern, short bursts mostly, now and then long.
  initial begin : rx_driver
    int left;
    int r;
    left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        r = $urandom_range(0, 9);
        if (rx_calm || r < 6) begin
          out_stall_i <= 1'b0;
          left = $urandom_range(1, 4);
        end else if (r < 9) begin
          out_stall_i <= 1'b1;
          left = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          left = $urandom_range(10, 40);
        end
      end
      left--;
    end
  end

  // Result checker: every output transfer is matched to the oldest owed one.
  always @(posedge clk_i) begin : nb_check
    nb_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (pending_nb_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer nb=(%0d,%0d,%0d) found=%b last=%b",
                                nb_x_o, nb_y_o, nb_z_o, found_o, last_o));
      end else begin
        want = pending_nb_q.pop_front();
        if (nb_x_o !== want.x)
          flag_mismatch($sformatf("nb_x got %0d want %0d", nb_x_o, want.x));
        if (nb_y_o !== want.y)
          flag_mismatch($sformatf("nb_y got %0d want %0d", nb_y_o, want.y));
        if (nb_z_o !== want.z)
          flag_mismatch($sformatf("nb_z got %0d want %0d", nb_z_o, want.z));
        if (found_o !== want.found)
          flag_mismatch($sformatf("found got %b want %b", found_o, want.found));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last got %b want %b", last_o, want.last));
      end
    end
  end

  // Watchdog, sized well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int   r;
    int   waited;
    cmd_e cmd;

    // all inputs known from time zero
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    command_i  <= CMD_FACE;
    cell_x_i   <= '0;
    cell_y_i   <= '0;
    cell_z_i   <= '0;
    grid_x = SIZE_W'(GRID_SIZE_MAX);
    grid_y = SIZE_W'(GRID_SIZE_MAX);
    grid_z = SIZE_W'(GRID_SIZE_MAX);

    // Directed probes. Sizes 1024 are the reset values, so the first rows
    // run on the grid as it comes out of reset.
    add_probe(1024, 1024, 1024, CMD_FACE,   0, 0, 0, 1'b0, NO_NB);
    add_probe(1024, 1024, 1024, CMD_EDGE,   1023, 1023, 1023, 1'b0, NO_NB);
    add_probe(1024, 1024, 1024, CMD_CORNER, 0, 0, 0, 1'b1,
              '{x: 10'd1, y: 10'd1, z: 10'd1, found: 1'b1, last: 1'b1});
    add_probe(1024, 1024, 1024, CMD_CORNER, 1023, 1023, 1023, 1'b1,
              '{x: 10'd1022, y: 10'd1022, z: 10'd1022, found: 1'b1, last: 1'b1});
    add_probe(1024, 1024, 1024, CMD_NONE,   512, 512, 512, 1'b1, NO_NB);
    add_probe(1024, 1024, 1024, CMD_EDGE,   512, 0, 512, 1'b0, NO_NB);
    add_probe(1024, 1024, 1024, CMD_FACE,   5, 6, 7, 1'b0, NO_NB);
    // single-cell grid: nothing can be a neighbor
    add_probe(1, 1, 1, CMD_FACE,   0, 0, 0, 1'b1, NO_NB);
    add_probe(1, 1, 1, CMD_EDGE,   0, 0, 0, 1'b1, NO_NB);
    add_probe(1, 1, 1, CMD_CORNER, 0, 0, 0, 1'b1, NO_NB);
    // empty grid
    add_probe(0, 0, 0, CMD_FACE,   0, 0, 0, 1'b1, NO_NB);
    add_probe(0, 0, 0, CMD_CORNER, 1023, 1023, 1023, 1'b1, NO_NB);
    // oversized registers clamp to the maximum
    add_probe(2047, 2047, 2047, CMD_FACE,   1023, 1023, 1023, 1'b0, NO_NB);
    add_probe(2047, 2047, 2047, CMD_CORNER, 1023, 0, 1023, 1'b0, NO_NB);
    add_probe(2047, 2047, 2047, CMD_EDGE,   1022, 1022, 1022, 1'b0, NO_NB);
    // centre outside the grid; in-grid candidates still come out
    add_probe(3, 5, 1024, CMD_FACE, 3, 2, 2, 1'b0, NO_NB);
    add_probe(3, 5, 1024, CMD_FACE, 4, 0, 0, 1'b1, NO_NB);
    add_probe(3, 5, 1024, CMD_EDGE, 1023, 1023, 0, 1'b0, NO_NB);
    add_probe(3, 5, 1024, CMD_NONE, 1, 1, 1, 1'b1, NO_NB);
    // flat grid: z has one layer, so corners never fit
    add_probe(2, 1024, 1, CMD_EDGE,   1, 500, 0, 1'b0, NO_NB);
    add_probe(2, 1024, 1, CMD_CORNER, 0, 1023, 0, 1'b1, NO_NB);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_list[i]) begin
      if (probe_list[i].sx != grid_x || probe_list[i].sy != grid_y ||
          probe_list[i].sz != grid_z)
        write_grid(probe_list[i].sx, probe_list[i].sy, probe_list[i].sz);
      send_item(probe_list[i].cmd, probe_list[i].x, probe_list[i].y, probe_list[i].z,
                probe_list[i].typed, probe_list[i].want);
    end

    // Random phases: fresh sizes each, some with no idling on one side.
    for (int ph = 0; ph < 6; ph++) begin
      write_grid(pick_size(), pick_size(), pick_size());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 48; i++) begin
        // occasional full drain mid-phase
        if ($urandom_range(0, 39) == 0) settle_block();
        r = $urandom_range(0, 9);
        case (r % 3)
          0:       cmd = CMD_FACE;
          1:       cmd = CMD_EDGE;
          default: cmd = CMD_CORNER;
        endcase
        if (r == 9) cmd = CMD_NONE;
        send_item(cmd, pick_cell(grid_x), pick_cell(grid_y), pick_cell(grid_z),
                  1'b0, NO_NB);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Drain, bounded; anything still owed afterwards is a failure.
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_nb_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    while (pending_nb_q.size() != 0) begin
      flag_mismatch("owed transfer never arrived");
      void'(pending_nb_q.pop_front());
    end

    $display("Run covered %0d input items and %0d neighbor transfers", items_sent,
             results_seen);
    $display("over %0d grid-size loads incl. empty, single-cell and clamped grids",
             grid_loads);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/vne_pkg.sv
hdl/vne_front.sv
hdl/vne_queue.sv
hdl/vne_back.sv
hdl/voxel_neighbour_enumerator.sv
bench/tb_voxel_neighbour_enumerator.sv
